// ===== rtl/core/bdq_pkg.sv =====
// shared types and codes for the bounded deque
package bdq_pkg;

    localparam int CMD_W   = 3;
    localparam int STS_W   = 3;
    localparam int DATA_W  = 32;
    localparam int CAP_W   = 6;

    localparam logic [CAP_W-1:0] CAP_RESET = 6'd32;

    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_LIST       = 3'd4;

    localparam logic [STS_W-1:0] STS_INSERTED = 3'd0;
    localparam logic [STS_W-1:0] STS_REMOVED  = 3'd1;
    localparam logic [STS_W-1:0] STS_FULL     = 3'd2;
    localparam logic [STS_W-1:0] STS_EMPTY    = 3'd3;
    localparam logic [STS_W-1:0] STS_LISTED   = 3'd4;

    typedef enum logic {
        IDLE,
        RUN
    } bdq_state_t;

endpackage

// ===== rtl/core/bdq_mem.sv =====
// entry storage: one write port, one registered read port
module bdq_mem
    import bdq_pkg::*;
#(
    parameter int DEPTH = 32,
    parameter int AW    = 5
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [AW-1:0]     raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/bounded_deque_unit.sv =====
// bounded deque top level: command decode, pointer control and result register
// push, full and empty results appear in the cycle after the command transfer
// pop results and the first listed entry pass through the memory read register, then the result register
// listing gives one entry per cycle while the result register is free
// the next command waits for the walk and a free result register; unstalled, a push every cycle
// reset clears head, count and result valid and sets capacity to 32; storage is not cleared
module bounded_deque_unit
    import bdq_pkg::*;
#(
    parameter int DEPTH = 32
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_wr_en,
    input  logic [CAP_W-1:0]         cfg_wr_data,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [CMD_W-1:0]         cmd,
    input  logic signed [DATA_W-1:0] value_in,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [STS_W-1:0]         status,
    output logic signed [DATA_W-1:0] value_out,
    output logic                     last
);

    localparam int IW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW  = $clog2(DEPTH + 1);
    localparam int SW  = CW + 1;
    localparam int CPW = (CW > CAP_W) ? CW : CAP_W;

    function automatic logic [IW-1:0] wrap(input logic [SW-1:0] sum);
        logic [SW-1:0] d;
        d = sum - SW'(DEPTH);
        return (sum >= SW'(DEPTH)) ? d[IW-1:0] : sum[IW-1:0];
    endfunction

    bdq_state_t          state_reg, state_next;
    logic [IW-1:0]       head_reg, head_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [CAP_W-1:0]    cap_reg;
    logic [IW-1:0]       ptr_reg, ptr_next;
    logic [CW-1:0]       rem_reg, rem_next;
    logic [STS_W-1:0]    run_sts_reg, run_sts_next;
    logic                out_valid_reg, out_valid_next;
    logic [STS_W-1:0]    status_reg, status_next;
    logic [DATA_W-1:0]   value_reg, value_next;
    logic                last_reg, last_next;

    logic                out_free;
    logic                accept;
    logic                out_load;
    logic                is_full;
    logic                is_empty;
    logic                mem_we;
    logic [IW-1:0]       mem_waddr;
    logic                mem_re;
    logic [IW-1:0]       mem_raddr;
    logic [DATA_W-1:0]   mem_rdata;

    bdq_mem #(
        .DEPTH (DEPTH),
        .AW    (IW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (value_in),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = !((state_reg == IDLE) && out_free);
    assign accept   = in_valid && !in_stall;
    assign is_full  = (CPW'(count_reg) >= CPW'(cap_reg)) || (count_reg == CW'(DEPTH));
    assign is_empty = (count_reg == '0);

    always_comb
    begin
        state_next   = state_reg;
        head_next    = head_reg;
        count_next   = count_reg;
        ptr_next     = ptr_reg;
        rem_next     = rem_reg;
        run_sts_next = run_sts_reg;
        out_load     = 1'b0;
        status_next  = status_reg;
        value_next   = value_reg;
        last_next    = last_reg;
        mem_we       = 1'b0;
        mem_waddr    = head_reg;
        mem_re       = 1'b0;
        mem_raddr    = head_reg;

        unique case (state_reg)
            IDLE:
            begin
                if (accept)
                begin
                    case (cmd) inside
                        CMD_PUSH_FRONT, CMD_PUSH_BACK:
                        begin
                            out_load   = 1'b1;
                            value_next = '0;
                            last_next  = 1'b1;
                            if (is_full)
                            begin
                                status_next = STS_FULL;
                            end
                            else
                            begin
                                status_next = STS_INSERTED;
                                mem_we      = 1'b1;
                                count_next  = count_reg + CW'(1);
                                if (cmd == CMD_PUSH_FRONT)
                                begin
                                    head_next = wrap(SW'(head_reg) + SW'(DEPTH - 1));
                                    mem_waddr = wrap(SW'(head_reg) + SW'(DEPTH - 1));
                                end
                                else
                                begin
                                    mem_waddr = wrap(SW'(head_reg) + SW'(count_reg));
                                end
                            end
                        end
                        CMD_POP_FRONT, CMD_POP_BACK:
                        begin
                            if (is_empty)
                            begin
                                out_load    = 1'b1;
                                status_next = STS_EMPTY;
                                value_next  = '0;
                                last_next   = 1'b1;
                            end
                            else
                            begin
                                mem_re       = 1'b1;
                                count_next   = count_reg - CW'(1);
                                rem_next     = '0;
                                run_sts_next = STS_REMOVED;
                                state_next   = RUN;
                                if (cmd == CMD_POP_FRONT)
                                begin
                                    mem_raddr = head_reg;
                                    head_next = wrap(SW'(head_reg) + SW'(1));
                                end
                                else
                                begin
                                    mem_raddr = wrap(SW'(head_reg) + SW'(count_reg) - SW'(1));
                                end
                            end
                        end
                        CMD_LIST:
                        begin
                            if (is_empty)
                            begin
                                out_load    = 1'b1;
                                status_next = STS_EMPTY;
                                value_next  = '0;
                                last_next   = 1'b1;
                            end
                            else
                            begin
                                mem_re       = 1'b1;
                                mem_raddr    = head_reg;
                                ptr_next     = wrap(SW'(head_reg) + SW'(1));
                                rem_next     = count_reg - CW'(1);
                                run_sts_next = STS_LISTED;
                                state_next   = RUN;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            RUN:
            begin
                // read data waits in the memory output until the result register frees
                if (out_free)
                begin
                    out_load    = 1'b1;
                    status_next = run_sts_reg;
                    value_next  = mem_rdata;
                    last_next   = (rem_reg == '0);
                    if (rem_reg == '0)
                    begin
                        state_next = IDLE;
                    end
                    else
                    begin
                        mem_re    = 1'b1;
                        mem_raddr = ptr_reg;
                        ptr_next  = wrap(SW'(ptr_reg) + SW'(1));
                        rem_next  = rem_reg - CW'(1);
                    end
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase

        out_valid_next = out_load || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            cap_reg       <= CAP_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                cap_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg     <= ptr_next;
        rem_reg     <= rem_next;
        run_sts_reg <= run_sts_next;
        if (out_load)
        begin
            status_reg <= status_next;
            value_reg  <= value_next;
            last_reg   <= last_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign value_out = value_reg;
    assign last      = last_reg;

endmodule

// ===== rtl/core/bdq_chk.sv =====
// port-level checks for the bounded deque, bound to the top level
module bdq_chk
    import bdq_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_valid,
    input logic                     in_stall,
    input logic [CMD_W-1:0]         cmd,
    input logic                     out_valid,
    input logic                     out_stall,
    input logic [STS_W-1:0]         status,
    input logic signed [DATA_W-1:0] value_out,
    input logic                     last
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // a push transfer gives its single result in the next cycle
    a_push_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (cmd == CMD_PUSH_FRONT || cmd == CMD_PUSH_BACK)
        |=> out_valid && last && (status == STS_INSERTED || status == STS_FULL))
        else $error("push transfer without matching result");

    // results that carry no entry show zero and end their command
    a_no_entry_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == STS_INSERTED || status == STS_FULL || status == STS_EMPTY)
        |-> (value_out == '0) && last)
        else $error("non-entry result with data or without last");

    // a removal is always a single result
    a_removed_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == STS_REMOVED) |-> last)
        else $error("removed entry not marked last");

endmodule

bind bounded_deque_unit bdq_chk u_bdq_chk (.*);

// ===== verif/bounded_deque_unit_tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the bounded deque unit: directed table, then random commands
module bounded_deque_unit_tb;
    import bdq_pkg::*;

    localparam int DEPTH       = 32;
    localparam int SLOT_W      = $clog2(DEPTH);
    localparam int QUIET_LIMIT = 2000;
    localparam int PHASES      = 11;

    localparam logic [CMD_W-1:0] CMD_RSVD_5 = 3'd5;
    localparam logic [CMD_W-1:0] CMD_RSVD_6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_RSVD_7 = 3'd7;

    typedef struct packed {
        logic [STS_W-1:0]  sts;
        logic [DATA_W-1:0] val;
        logic              lst;
    } deque_result_t;

    typedef struct packed {
        logic [CMD_W-1:0]  op;
        logic [DATA_W-1:0] arg;
        logic              typed;
        logic [STS_W-1:0]  want_sts;
        logic [DATA_W-1:0] want_val;
    } directed_row_t;

    logic                     clk         = 1'b0;
    logic                     rst_n       = 1'b0;
    logic                     cfg_wr_en   = 1'b0;
    logic [CAP_W-1:0]         cfg_wr_data = '0;
    logic                     in_valid    = 1'b0;
    logic                     in_stall;
    logic [CMD_W-1:0]         cmd         = '0;
    logic signed [DATA_W-1:0] value_in    = '0;
    logic                     out_valid;
    logic                     out_stall   = 1'b0;
    logic [STS_W-1:0]         status;
    logic signed [DATA_W-1:0] value_out;
    logic                     last;

    // deque shadow state
    logic [DATA_W-1:0] store_mem [DEPTH];
    int unsigned       front_slot   = 0;
    int unsigned       stored_count = 0;
    logic [CAP_W-1:0]  cap_reg      = CAP_RESET;

    deque_result_t expected_results [$];
    directed_row_t directed_rows [$];

    bit tx_burst    = 1'b0;
    bit rx_burst    = 1'b0;
    int stall_left  = 0;
    int quiet_cycles = 0;

    int mismatches      = 0;
    int commands_sent   = 0;
    int results_checked = 0;
    int full_reports    = 0;
    int empty_reports   = 0;
    int longest_list    = 0;
    int cap_writes      = 0;

    int phase_cap  [PHASES] = '{0, 1, 2, 63, 3, 32, 33, 17, 1, 5, 31};
    int phase_push [PHASES] = '{55, 50, 50, 88, 35, 55, 45, 50, 45, 40, 30};
    int phase_len  [PHASES] = '{27, 27, 27, 45, 27, 27, 27, 27, 27, 27, 27};

    bounded_deque_unit #(
        .DEPTH (DEPTH)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cmd         (cmd),
        .value_in    (value_in),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .value_out   (value_out),
        .last        (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void queue_expected(input logic [STS_W-1:0] s, input logic [DATA_W-1:0] v,
                                           input logic l);
        deque_result_t r;
        r.sts = s;
        r.val = v;
        r.lst = l;
        expected_results.push_back(r);
    endfunction

    function automatic void predict_deque(input logic [CMD_W-1:0] op, input logic [DATA_W-1:0] v);
        int unsigned usable;
        int unsigned slot;
        usable = (cap_reg > DEPTH) ? DEPTH : cap_reg;
        case (op) inside
            CMD_PUSH_FRONT, CMD_PUSH_BACK:
            begin
                if (stored_count >= usable)
                begin
                    queue_expected(STS_FULL, '0, 1'b1);
                    full_reports++;
                end
                else
                begin
                    if (op == CMD_PUSH_FRONT)
                    begin
                        front_slot = (front_slot + DEPTH - 1) % DEPTH;
                        store_mem[SLOT_W'(front_slot)] = v;
                    end
                    else
                        store_mem[SLOT_W'((front_slot + stored_count) % DEPTH)] = v;
                    stored_count++;
                    queue_expected(STS_INSERTED, '0, 1'b1);
                end
            end
            CMD_POP_FRONT, CMD_POP_BACK:
            begin
                if (stored_count == 0)
                begin
                    queue_expected(STS_EMPTY, '0, 1'b1);
                    empty_reports++;
                end
                else
                begin
                    if (op == CMD_POP_FRONT)
                    begin
                        slot = front_slot;
                        front_slot = (front_slot + 1) % DEPTH;
                    end
                    else
                        slot = (front_slot + stored_count - 1) % DEPTH;
                    stored_count--;
                    queue_expected(STS_REMOVED, store_mem[SLOT_W'(slot)], 1'b1);
                end
            end
            CMD_LIST:
            begin
                if (stored_count == 0)
                begin
                    queue_expected(STS_EMPTY, '0, 1'b1);
                    empty_reports++;
                end
                else
                begin
                    for (int unsigned k = 0; k < stored_count; k++)
                        queue_expected(STS_LISTED,
                                       store_mem[SLOT_W'((front_slot + k) % DEPTH)],
                                       k + 1 == stored_count);
                    if (stored_count > longest_list)
                        longest_list = stored_count;
                end
            end
            default:
                ;
        endcase
    endfunction

    function automatic void check_result(input logic [STS_W-1:0] s, input logic [DATA_W-1:0] v,
                                         input logic l);
        deque_result_t want;
        results_checked++;
        if (expected_results.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected transfer: status %0d value %h last %0d", s, v, l);
        end
        else
        begin
            want = expected_results.pop_front();
            if (want.sts !== s || want.val !== v || want.lst !== l)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected status %0d value %h last %0d, got %0d %h %0d",
                             want.sts, want.val, want.lst, s, v, l);
            end
        end
    endfunction

    function automatic void add_row(input logic [CMD_W-1:0] op, input logic [DATA_W-1:0] arg,
                                    input logic typed, input logic [STS_W-1:0] s,
                                    input logic [DATA_W-1:0] v);
        directed_row_t row;
        row.op       = op;
        row.arg      = arg;
        row.typed    = typed;
        row.want_sts = s;
        row.want_val = v;
        directed_rows.push_back(row);
    endfunction

    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_command(input logic [CMD_W-1:0] op, input logic [DATA_W-1:0] arg);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 11);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= op;
        value_in <= arg;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_deque(op, arg);
        commands_sent++;
    endtask

    task automatic settle(input int extra);
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic set_capacity(input logic [CAP_W-1:0] c);
        settle(4);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= c;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        cap_reg = c;
        cap_writes++;
    endtask

    // result side: check each transfer, then hold off for a drawn number of cycles
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            check_result(status, value_out, last);
            stall_left = rx_burst ? 0 : $urandom_range(0, 11);
            out_stall <= (stall_left != 0);
        end
        else if (stall_left != 0)
        begin
            stall_left--;
            out_stall <= (stall_left != 0);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
            $display("[bounded_deque_unit] ERROR");
            $finish;
        end
    end

    initial
    begin : stimulus
        directed_row_t    row;
        logic [CMD_W-1:0] op;
        int               r;

        add_row(CMD_POP_FRONT,  32'h0,         1'b1, STS_EMPTY,    32'h0);
        add_row(CMD_POP_BACK,   32'h0,         1'b1, STS_EMPTY,    32'h0);
        add_row(CMD_LIST,       32'h0,         1'b1, STS_EMPTY,    32'h0);
        add_row(CMD_PUSH_FRONT, 32'h7fff_ffff, 1'b1, STS_INSERTED, 32'h0);
        add_row(CMD_PUSH_BACK,  32'h8000_0000, 1'b1, STS_INSERTED, 32'h0);
        add_row(CMD_PUSH_FRONT, 32'hffff_ffff, 1'b1, STS_INSERTED, 32'h0);
        add_row(CMD_PUSH_BACK,  32'h0,         1'b1, STS_INSERTED, 32'h0);
        add_row(CMD_LIST,       32'h0,         1'b0, STS_LISTED,   32'h0);
        add_row(CMD_RSVD_5,     32'h1234_5678, 1'b0, STS_INSERTED, 32'h0);
        add_row(CMD_RSVD_6,     32'hffff_ffff, 1'b0, STS_INSERTED, 32'h0);
        add_row(CMD_RSVD_7,     32'h0,         1'b0, STS_INSERTED, 32'h0);
        add_row(CMD_POP_FRONT,  32'h0,         1'b1, STS_REMOVED,  32'hffff_ffff);
        add_row(CMD_POP_BACK,   32'h0,         1'b1, STS_REMOVED,  32'h0);
        add_row(CMD_LIST,       32'h0,         1'b0, STS_LISTED,   32'h0);
        add_row(CMD_POP_BACK,   32'h0,         1'b1, STS_REMOVED,  32'h8000_0000);
        add_row(CMD_POP_FRONT,  32'h0,         1'b1, STS_REMOVED,  32'h7fff_ffff);
        add_row(CMD_POP_FRONT,  32'h0,         1'b1, STS_EMPTY,    32'h0);
        add_row(CMD_PUSH_BACK,  32'h5a5a_a5a5, 1'b1, STS_INSERTED, 32'h0);
        add_row(CMD_POP_FRONT,  32'h0,         1'b0, STS_REMOVED,  32'h0);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            send_command(row.op, row.arg);
            if (row.typed)
            begin
                void'(expected_results.pop_back());
                queue_expected(row.want_sts, row.want_val, 1'b1);
            end
        end

        for (int p = 0; p < PHASES; p++)
        begin
            set_capacity(CAP_W'(phase_cap[p]));
            tx_burst = (p % 3 == 1);
            rx_burst = (p % 4 == 2);
            for (int i = 0; i < phase_len[p]; i++)
            begin
                r = $urandom_range(0, 99);
                if (r < 2)
                begin
                    case ($urandom_range(0, 2))
                        0: op = CMD_RSVD_5;
                        1: op = CMD_RSVD_6;
                        default: op = CMD_RSVD_7;
                    endcase
                end
                else if (r < 8)
                    op = CMD_LIST;
                else if (r < 8 + phase_push[p])
                    op = $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
                else
                    op = $urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT;
                send_command(op, pick_value());
                // occasional full drain before the next transfer
                if ($urandom_range(0, 24) == 0)
                    settle(1);
            end
        end

        settle(8);
        mismatches += expected_results.size();

        $display("%0d commands over %0d capacity settings, %0d results checked",
                 commands_sent, cap_writes, results_checked);
        $display("%0d full and %0d empty reports, longest listing %0d entries",
                 full_reports, empty_reports, longest_list);
        if (mismatches == 0)
            $display("[bounded_deque_unit] OK");
        else
            $display("[bounded_deque_unit] ERROR");
        $finish;
    end

endmodule
